// ===== rtl/core/wllc_pkg.sv =====
// ----------------------------------------------------------------------------
// wllc_pkg
// Types and constants shared by the wavelet level length calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package wllc_pkg;

	localparam int LEN_W     = 16;
	localparam int LVL_W     = 4;
	localparam int NUM_STEPS = 16;
	localparam int DEPTH_W   = 5;
	localparam int EXT_W     = 8;
	localparam int TOTAL_W   = 18;
	localparam int LEVEL_W   = 17;
	localparam int ACC_W     = 20;
	localparam int BOUND_W   = 18;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [BOUND_W-1:0] FIT_MARGIN = BOUND_W'(12);
	localparam logic [ACC_W-1:0]   TOTAL_MAX  = ACC_W'(262143);

	typedef enum logic [1:0] {
		REG_BORDER = 2'd0,
		REG_APPROX = 2'd1,
		REG_DETAIL = 2'd2
	} wllc_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0] signal_len;
		logic [LVL_W-1:0] level_index;
	} wllc_in_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_len;
		logic [LEVEL_W-1:0] approx_len;
		logic [LEVEL_W-1:0] detail_len;
		logic               power_two_fallback;
		logic               len_error;
	} wllc_out_t;

	typedef struct packed {
		logic [EXT_W-1:0] border_extent;
		logic [EXT_W-1:0] approx_extent;
		logic [EXT_W-1:0] detail_extent;
	} wllc_cfg_t;

	typedef struct packed {
		logic               len_one;
		logic               err;
		logic [DEPTH_W-1:0] depth;
		logic [LVL_W-1:0]   level;
		logic [LEN_W-1:0]   cur;
		logic [ACC_W-1:0]   total;
		logic               total_active;
		logic [LEVEL_W-1:0] approx;
		logic [LEVEL_W-1:0] detail;
		logic               fallback;
	} wllc_walk_t;

endpackage

`default_nettype wire

// ===== rtl/core/wllc_regs.sv =====
// ----------------------------------------------------------------------------
// wllc_regs
// APB register file holding the three extent settings.
// ----------------------------------------------------------------------------
`default_nettype none

module wllc_regs
	import wllc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output wllc_cfg_t          cfg
);

	wllc_cfg_t cfg_q;
	wllc_reg_t sel;

	assign sel    = wllc_reg_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (sel)
				REG_BORDER: cfg_q.border_extent <= pwdata[EXT_W-1:0];
				REG_APPROX: cfg_q.approx_extent <= pwdata[EXT_W-1:0];
				REG_DETAIL: cfg_q.detail_extent <= pwdata[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_BORDER: prdata = PDATA_W'(cfg_q.border_extent);
			REG_APPROX: prdata = PDATA_W'(cfg_q.approx_extent);
			REG_DETAIL: prdata = PDATA_W'(cfg_q.detail_extent);
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/wllc_front.sv =====
// ----------------------------------------------------------------------------
// wllc_front
// Length check and walk depth (ceil log2 of the trimmed length).
// ----------------------------------------------------------------------------
`default_nettype none

module wllc_front
	import wllc_pkg::*;
(
	input  wllc_in_t   query,
	input  wllc_cfg_t  cfg,
	output wllc_walk_t walk
);

	logic [LEN_W-1:0]   span;
	logic [DEPTH_W-1:0] msb_len;
	logic               err;
	logic               len_one;

	assign err     = query.signal_len <= LEN_W'(cfg.border_extent);
	assign len_one = query.signal_len == LEN_W'(1);
	assign span    = query.signal_len - LEN_W'(cfg.border_extent) - LEN_W'(1);

	// bit length of span
	always_comb begin
		msb_len = '0;
		for (int b = 0; b < LEN_W; b++) begin
			if (span[b]) begin
				msb_len = DEPTH_W'(b + 1);
			end
		end
	end

	always_comb begin
		walk              = '0;
		walk.len_one      = len_one;
		walk.err          = err;
		walk.depth        = (msb_len == '0) ? DEPTH_W'(1) : msb_len;
		walk.level        = query.level_index;
		walk.cur          = query.signal_len;
		walk.total_active = !len_one;
	end

endmodule

`default_nettype wire

// ===== rtl/core/wllc_step.sv =====
// ----------------------------------------------------------------------------
// wllc_step
// One level of the walk: fit test against the power-of-two bound, halving,
// total accumulation and level capture.
// ----------------------------------------------------------------------------
`default_nettype none

module wllc_step
	import wllc_pkg::*;
(
	input  logic [LVL_W-1:0] step_idx,
	input  wllc_cfg_t        cfg,
	input  wllc_walk_t       walk_in,
	output wllc_walk_t       walk_out
);

	logic [DEPTH_W-1:0] idx;
	logic [BOUND_W-1:0] pow;
	logic [BOUND_W-1:0] bound;
	logic [BOUND_W-1:0] need;
	logic [LEN_W-2:0]   half;
	logic [LEVEL_W-1:0] det;
	logic               fit;
	logic               in_total;
	logic               in_level;

	assign idx      = DEPTH_W'(step_idx);
	assign pow      = (walk_in.depth >= idx) ? (BOUND_W'(1) << (walk_in.depth - idx)) : '0;
	assign bound    = pow + BOUND_W'(cfg.border_extent);
	assign need     = BOUND_W'(walk_in.cur) + FIT_MARGIN;
	assign fit      = need <= bound;
	assign half     = walk_in.cur[LEN_W-1:1];
	assign det      = LEVEL_W'(half) + LEVEL_W'(cfg.detail_extent);
	assign in_total = walk_in.total_active && (idx < walk_in.depth);
	assign in_level = step_idx <= walk_in.level;

	always_comb begin
		walk_out = walk_in;
		if (fit) begin
			walk_out.cur = LEN_W'(half) + LEN_W'(cfg.approx_extent);
		end
		if (in_total) begin
			if (fit) begin
				walk_out.total = walk_in.total + ACC_W'(det);
			end else begin
				walk_out.total        = walk_in.total + ACC_W'(bound);
				walk_out.total_active = 1'b0;
			end
		end
		if (in_level) begin
			if (fit) begin
				walk_out.approx = LEVEL_W'(walk_in.cur);
				walk_out.detail = det;
			end else begin
				walk_out.approx   = LEVEL_W'(bound);
				walk_out.detail   = LEVEL_W'(pow >> 1);
				walk_out.fallback = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wavelet_level_length_calc.sv =====
// ----------------------------------------------------------------------------
// wavelet_level_length_calc
// Buffer sizes for a multilevel wavelet decomposition of arbitrary length.
// ----------------------------------------------------------------------------
// Takes one query per clock unless the pipeline is stalled. Stages: one for
// the length check and depth, then one per decomposition level (16 levels,
// one fit test and add each), then the output register. A stall on a valid
// result freezes the whole pipeline, so the query side stalls in the same
// cycle. Extent registers are to be written only while no query is in
// flight.
`default_nettype none

module wavelet_level_length_calc
	import wllc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               query_valid,
	output logic               query_stall,
	input  wllc_in_t           query,
	output logic               sizes_valid,
	input  logic               sizes_stall,
	output wllc_out_t          sizes
);

	wllc_cfg_t          cfg;
	wllc_walk_t         front_walk;
	wllc_walk_t         step_walk [NUM_STEPS];
	wllc_walk_t         walk_sn   [NUM_STEPS+1];
	logic [NUM_STEPS:0] valid_sn;
	wllc_walk_t         last;
	wllc_out_t          fin;
	wllc_out_t          sizes_q;
	logic               sizes_valid_q;
	logic               adv;

	wllc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wllc_front u_front (
		.query (query),
		.cfg   (cfg),
		.walk  (front_walk)
	);

	for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
		wllc_step u_step (
			.step_idx (LVL_W'(k)),
			.cfg      (cfg),
			.walk_in  (walk_sn[k]),
			.walk_out (step_walk[k])
		);
	end

	assign adv         = !(sizes_valid_q && sizes_stall);
	assign query_stall = !adv;
	assign sizes_valid = sizes_valid_q;
	assign sizes       = sizes_q;
	assign last        = walk_sn[NUM_STEPS];

	always_comb begin
		fin           = '0;
		fin.len_error = last.err;
		if (last.len_one) begin
			fin.total_len = TOTAL_W'(1);
		end else if (!last.err) begin
			fin.total_len = (last.total > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(last.total);
		end
		if (!last.err) begin
			fin.approx_len         = last.approx;
			fin.detail_len         = last.detail;
			fin.power_two_fallback = last.fallback;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn      <= '0;
			sizes_valid_q <= 1'b0;
		end else if (adv) begin
			valid_sn      <= {valid_sn[NUM_STEPS-1:0], query_valid};
			sizes_valid_q <= valid_sn[NUM_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			walk_sn[0] <= front_walk;
			for (int k = 0; k < NUM_STEPS; k++) begin
				walk_sn[k+1] <= step_walk[k];
			end
			sizes_q <= fin;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wllc_checker.sv =====
// ----------------------------------------------------------------------------
// wllc_checker
// Port-level checks for the wavelet level length calculator.
// ----------------------------------------------------------------------------
`default_nettype none

module wllc_checker
	import wllc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      query_stall,
	input logic      sizes_valid,
	input logic      sizes_stall,
	input wllc_out_t sizes
);

	// stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sizes_valid && sizes_stall |=> sizes_valid && $stable(sizes))
		else $error("result changed while stalled");

	// query side only stalls behind a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> sizes_valid && sizes_stall)
		else $error("query stalled without result stall");

	// length error clears the level figures
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		sizes_valid && sizes.len_error |-> sizes.approx_len == '0 &&
		sizes.detail_len == '0 && !sizes.power_two_fallback &&
		sizes.total_len <= TOTAL_W'(1))
		else $error("length error with nonzero sizes");

	// nothing comes out of a fresh reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !sizes_valid)
		else $error("result valid right after reset");

endmodule

bind wavelet_level_length_calc wllc_checker u_chk (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wavelet_level_length_calc. A directed table covers
// length errors, length one, the ends of the length and level fields and the
// fit margin around powers of two. Random queries follow over several extent
// settings and idle patterns. Every result is checked against a predictor in
// the bench, or against the known values of a typed directed row.
// ----------------------------------------------------------------------------
module tb;
	import wllc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY     = 18;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LEN_MARGIN  = 12;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		wllc_cfg_t cfg;
		wllc_in_t  q;
		logic      typed;
		wllc_out_t known;
	} probe_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                query_valid;
	logic                query_stall;
	wllc_in_t            query;
	logic                sizes_valid;
	logic                sizes_stall = 1'b0;
	wllc_out_t           sizes;

	wllc_cfg_t           extents;
	wllc_out_t           pending_sizes[$];
	wllc_out_t           due;
	probe_t              directed_rows[$];
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  fails = 0;
	int unsigned         cycles = 0;

	wavelet_level_length_calc DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.query(query),
		.sizes_valid(sizes_valid),
		.sizes_stall(sizes_stall),
		.sizes(sizes)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		sizes_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	function automatic wllc_out_t level_sizes(wllc_in_t q, wllc_cfg_t c);
		longint len, lvl, b, ax, dx, total, appr, det, cur, v, bound;
		int depth, i;
		bit fb, err;
		wllc_out_t r;
		len = q.signal_len;
		lvl = q.level_index;
		b = c.border_extent;
		ax = c.approx_extent;
		dx = c.detail_extent;
		total = (len == 1) ? 1 : 0;
		appr = 0;
		det = 0;
		fb = 0;
		err = (len <= b);
		if (!err) begin
			v = len - b - 1;
			depth = 0;
			while (v != 0) begin
				depth++;
				v >>= 1;
			end
			if (depth < 1)
				depth = 1;
			cur = len;
			if (len != 1) begin
				for (i = 0; i < depth; i++) begin
					bound = longint'(1) << (depth - i);
					if (cur + LEN_MARGIN <= bound + b) begin
						total += cur / 2 + dx;
						cur = cur / 2 + ax;
					end else begin
						total += bound + b;
						break;
					end
				end
			end
			cur = len;
			for (i = 0; i <= lvl; i++) begin
				bound = (i > depth) ? 0 : (longint'(1) << (depth - i));
				if (cur + LEN_MARGIN <= bound + b) begin
					appr = cur;
					det = cur / 2 + dx;
					cur = cur / 2 + ax;
				end else begin
					appr = bound + b;
					det = bound / 2;
					fb = 1;
				end
			end
		end
		r.total_len = (total > 262143) ? 18'h3ffff : TOTAL_W'(total);
		r.approx_len = (appr > 131071) ? 17'h1ffff : LEVEL_W'(appr);
		r.detail_len = (det > 131071) ? 17'h1ffff : LEVEL_W'(det);
		r.power_two_fallback = fb;
		r.len_error = err;
		return r;
	endfunction

	function automatic probe_t row(int b, int a, int d, int len, int lvl, bit typed = 1'b0,
		int tot = 0, int ap = 0, int dt = 0, bit fb = 1'b0, bit er = 1'b0);
		probe_t p;
		p.cfg = '{EXT_W'(b), EXT_W'(a), EXT_W'(d)};
		p.q = '{LEN_W'(len), LVL_W'(lvl)};
		p.typed = typed;
		p.known = '{TOTAL_W'(tot), LEVEL_W'(ap), LEVEL_W'(dt), fb, er};
		return p;
	endfunction

	function automatic logic [EXT_W-1:0] random_extent();
		int sel;
		sel = $urandom_range(99);
		if (sel < 25)
			return '0;
		if (sel < 50)
			return '1;
		return EXT_W'($urandom_range(255));
	endfunction

	function automatic wllc_in_t random_query(wllc_cfg_t c);
		wllc_in_t q;
		int sel, len;
		sel = $urandom_range(99);
		if (sel < 40)
			len = c.border_extent + (1 << $urandom_range(1, 16)) - $urandom_range(0, 20);
		else if (sel < 55)
			len = $urandom_range(0, c.border_extent + 2);
		else if (sel < 65)
			len = $urandom_range(0, 300);
		else
			len = $urandom_range(0, 65535);
		if (len > 65535)
			len = 65535;
		q.signal_len = LEN_W'(len);
		q.level_index = LVL_W'($urandom_range(15));
		return q;
	endfunction

	task automatic check_field(string name, int unsigned exp, int unsigned act);
		if (exp != act) begin
			$display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp, act);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && sizes_valid && !sizes_stall) begin
			if (pending_sizes.size() == 0) begin
				$display("%0t: unexpected transaction total_len %0d", $time, sizes.total_len);
				fails++;
			end else begin
				due = pending_sizes.pop_front();
				check_field("total_len", due.total_len, sizes.total_len);
				check_field("approx_len", due.approx_len, sizes.approx_len);
				check_field("detail_len", due.detail_len, sizes.detail_len);
				check_field("power_two_fallback", due.power_two_fallback,
					sizes.power_two_fallback);
				check_field("len_error", due.len_error, sizes.len_error);
			end
		end
	end

	task automatic wait_drained();
		while (pending_sizes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(wllc_reg_t idx, logic [EXT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * idx);
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_extents(wllc_cfg_t c);
		query_valid <= 1'b0;
		wait_drained();
		reg_write(REG_BORDER, c.border_extent);
		reg_write(REG_APPROX, c.approx_extent);
		reg_write(REG_DETAIL, c.detail_extent);
		extents = c;
	endtask

	task automatic send_query(wllc_in_t q, logic typed, wllc_out_t known);
		while ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 1'b0;
			@(negedge clk);
		end
		query_valid <= 1'b1;
		query <= q;
		do @(posedge clk); while (query_stall);
		pending_sizes.push_back(typed ? known : level_sizes(q, extents));
		@(negedge clk);
	endtask

	initial begin
		wllc_cfg_t c;
		int ph, n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		query_valid = 1'b0;
		query = '0;
		extents = '0;
		directed_rows = '{
			row(0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0, 1'b1),
			row(0, 0, 0, 1, 0, 1'b1, 1, 2, 1, 1'b1, 1'b0),
			row(0, 0, 0, 1, 15, 1'b1, 1, 0, 0, 1'b1, 1'b0),
			row(0, 0, 0, 65535, 0),
			row(0, 0, 0, 65535, 15),
			row(0, 0, 0, 65524, 3),
			row(0, 0, 0, 65525, 15),
			row(0, 0, 0, 2, 0),
			row(0, 0, 0, 4, 1),
			row(0, 0, 0, 1024, 5),
			row(0, 0, 0, 1012, 9),
			row(0, 0, 0, 1013, 9),
			row(0, 0, 0, 20, 15),
			row(255, 255, 255, 0, 15, 1'b1, 0, 0, 0, 1'b0, 1'b1),
			row(255, 255, 255, 1, 7, 1'b1, 1, 0, 0, 1'b0, 1'b1),
			row(255, 255, 255, 255, 0, 1'b1, 0, 0, 0, 1'b0, 1'b1),
			row(255, 255, 255, 256, 0),
			row(255, 255, 255, 65535, 15),
			row(255, 255, 255, 40000, 7),
			row(200, 0, 255, 200, 3, 1'b1, 0, 0, 0, 1'b0, 1'b1),
			row(200, 0, 255, 212, 2),
			row(200, 0, 255, 8380, 10),
			row(0, 255, 0, 65535, 15),
			row(0, 255, 0, 5000, 12)
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_extents('0);
		foreach (directed_rows[k]) begin
			if (directed_rows[k].cfg != extents)
				set_extents(directed_rows[k].cfg);
			send_query(directed_rows[k].q, directed_rows[k].typed, directed_rows[k].known);
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			query_valid <= 1'b0;
			@(negedge clk);
			if (ph == 0)
				c = '0;
			else if (ph == 1)
				c = '1;
			else
				c = '{random_extent(), random_extent(), random_extent()};
			set_extents(c);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 59;
				end
				default: begin
					send_idle_pct = 26;
					stall_pct = 26;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == PHASE_ITEMS / 2) begin
					query_valid <= 1'b0;
					@(negedge clk);
					wait_drained();
				end
				send_query(random_query(extents), 1'b0, '0);
			end
		end

		query_valid <= 1'b0;
		send_idle_pct = 0;
		while (pending_sizes.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/wllc_pkg.sv
rtl/core/wllc_regs.sv
rtl/core/wllc_front.sv
rtl/core/wllc_step.sv
rtl/core/wavelet_level_length_calc.sv
rtl/core/wllc_checker.sv
verif/tb.sv
